FILE: src/assert_macros.svh
// Assertion helpers used by the decoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a rising clock, muted while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Signal pair that must never be high together.
`define ASSERT_NEVER_BOTH(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) \
    else $error("assertion failed");

`endif

FILE: src/upd_pkg.sv
package upd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNul     = 8'h00;

  localparam int MaxResults = 3;
  localparam int CntW       = $clog2(MaxResults + 1);

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // One input's worth of output bytes; term marks the last byte as terminator.
  typedef struct packed {
    logic [CntW-1:0]                  cnt;
    logic                             term;
    logic [MaxResults-1:0][7:0]       bytes;
  } job_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } queue_status_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
             (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (v >= "a") v = v - 8'd32;
    if (v >= "A") v = v - 8'd55;
    else v = v - 8'd48;
    hex_value = v[3:0];
  endfunction

endpackage

FILE: src/upd_front.sv
module upd_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic [7:0]   in_byte_i,
  output logic         in_stall_o,
  input  logic         q_full_i,
  output logic         push_o,
  output upd_pkg::job_t job_o
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  always_comb begin
    logic [upd_pkg::CntW-1:0] n;
    logic                     do_plain;
    n        = '0;
    do_plain = 1'b0;
    job_o    = '0;
    phase_d  = PH_IDLE;
    held_d   = held_q;
    case (phase_q)
      PH_PCT: begin
        if (upd_pkg::is_hex(in_byte_i)) begin
          held_d  = in_byte_i;
          phase_d = PH_DIGIT;
        end else begin
          job_o.bytes[0] = upd_pkg::ChPercent;
          n        = upd_pkg::CntW'(1);
          do_plain = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (upd_pkg::is_hex(in_byte_i)) begin
          job_o.bytes[0] = {upd_pkg::hex_value(held_q), upd_pkg::hex_value(in_byte_i)};
          n = upd_pkg::CntW'(1);
        end else begin
          job_o.bytes[0] = upd_pkg::ChPercent;
          job_o.bytes[1] = held_q;
          n        = upd_pkg::CntW'(2);
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase
    if (do_plain) begin
      case (in_byte_i)
        upd_pkg::ChNul: begin
          job_o.bytes[n[1:0]] = upd_pkg::ChNul;
          job_o.term          = 1'b1;
          n = n + upd_pkg::CntW'(1);
        end
        upd_pkg::ChPercent: phase_d = PH_PCT;
        upd_pkg::ChPlus: begin
          job_o.bytes[n[1:0]] = upd_pkg::ChSpace;
          n = n + upd_pkg::CntW'(1);
        end
        default: begin
          job_o.bytes[n[1:0]] = in_byte_i;
          n = n + upd_pkg::CntW'(1);
        end
      endcase
    end
    job_o.cnt = n;
  end

  // Inputs that only open or extend an escape produce no queue entry.
  assign push_o = accept & (job_o.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

FILE: src/upd_queue.sv
module upd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  upd_pkg::job_t          push_job_i,
  input  logic                   pop_i,
  output upd_pkg::job_t          head_o,
  output upd_pkg::queue_status_t status_o
);

  upd_pkg::job_t                  mem_q [upd_pkg::QueueDepth];
  logic [upd_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [upd_pkg::QCntW-1:0]      count_q;

  assign head_o          = mem_q[rd_ptr_q];
  assign status_o.count  = count_q;
  assign status_o.full   = (count_q == upd_pkg::QCntW'(upd_pkg::QueueDepth));
  assign status_o.empty  = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + upd_pkg::QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + upd_pkg::QPtrW'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + upd_pkg::QCntW'(1);
        2'b01:   count_q <= count_q - upd_pkg::QCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: src/upd_back.sv
module upd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  upd_pkg::job_t head_i,
  input  logic          q_empty_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          string_end_o,
  output logic          run_last_o
);

  upd_pkg::job_t cur_q;
  logic          cur_valid_q;
  logic [1:0]    idx_q;
  logic          last, take, done;

  assign last  = (idx_q == 2'(cur_q.cnt - upd_pkg::CntW'(1)));
  assign take  = cur_valid_q & ~out_stall_i;
  assign done  = take & last;
  assign pop_o = (~cur_valid_q | done) & ~q_empty_i;

  assign out_valid_o  = cur_valid_q;
  assign out_byte_o   = cur_q.bytes[idx_q];
  assign run_last_o   = last;
  assign string_end_o = cur_q.term & last;

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (done) begin
      cur_valid_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

FILE: src/url_percent_decoder_core.sv
// URL percent decoder (form-urlencoded), one source byte per transaction.
// Input channel: in_valid_i / in_stall_o carry in_byte_i; a zero byte ends
// the string. Output channel: out_valid_o / out_stall_i carry out_byte_o,
// string_end_o (the terminator) and run_last_o (last byte from one input).
// Each input yields zero to three output transactions: '+' gives a space,
// "%hh" gives the decoded byte on its last digit, broken escapes flush '%'
// and the held digit literally ahead of the breaking byte.
// Results pass through the job queue and then the emitter's job register.
// Throughput: one input per cycle while the four-entry job queue has room;
// the output drains one byte per cycle unless stalled, so inputs that
// expand into two or three bytes slow the source only once the queue fills.
// The front classifier accepts and updates escape state; the back emitter
// walks each queued job one byte at a time.
// Reset (rst_ni low, asynchronous) clears escape state, empties the queue
// and drops any partly emitted job. A stalled output holds its byte; input
// stall rises only when the queue is full.
`include "assert_macros.svh"

module url_percent_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       string_end_o,
  output logic       run_last_o
);

  upd_pkg::job_t          push_job, head_job;
  upd_pkg::queue_status_t q_status;
  logic                   push, pop;

  // Front: classify the byte and build a job of up to three bytes.
  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_status.full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Short job queue decoupling the two sides.
  upd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .status_o   (q_status)
  );

  // Back: emit the head job one byte per output transaction.
  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .q_empty_i    (q_status.empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .string_end_o (string_end_o),
    .run_last_o   (run_last_o)
  );

  `ASSERT_CLK(a_q_count_bound, clk_i, rst_ni, q_status.count <= upd_pkg::QCntW'(upd_pkg::QueueDepth))
  `ASSERT_NEVER_BOTH(a_pop_empty, clk_i, rst_ni, pop, q_status.empty)
  `ASSERT_NEVER_BOTH(a_push_full, clk_i, rst_ni, push, q_status.full)
  `ASSERT_CLK(a_end_is_last, clk_i, rst_ni, (out_valid_o && string_end_o) |-> run_last_o)

endmodule

FILE: tb/percent_decode_checker.sv
module percent_decode_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       string_end_i,
  input  logic       run_last_i,
  output int         mismatch_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PhIdle,
    PhPercent,
    PhDigit
  } escape_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic       last;
  } decoded_t;

  escape_phase_e escape_phase = PhIdle;
  logic [7:0]    held_digit   = '0;
  decoded_t      decoded_q[$];

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  function automatic logic hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
           (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c >= "a") v = c - "a" + 8'd10;
    else if (c >= "A") v = c - "A" + 8'd10;
    else v = c - "0";
    return v[3:0];
  endfunction

  task automatic emit(input logic [7:0] b, input logic t);
    decoded_q.push_back('{data: b, term: t, last: 1'b0});
  endtask

  // byte seen with no escape open
  task automatic take_plain(input logic [7:0] c);
    escape_phase = PhIdle;
    if (c == upd_pkg::ChNul) emit(upd_pkg::ChNul, 1'b1);
    else if (c == upd_pkg::ChPercent) escape_phase = PhPercent;
    else if (c == upd_pkg::ChPlus) emit(upd_pkg::ChSpace, 1'b0);
    else emit(c, 1'b0);
  endtask

  task automatic decode_step(input logic [7:0] c);
    int n0;
    n0 = decoded_q.size();
    case (escape_phase)
      PhPercent: begin
        if (hex_digit(c)) begin
          held_digit   = c;
          escape_phase = PhDigit;
        end else begin
          emit(upd_pkg::ChPercent, 1'b0);
          take_plain(c);
        end
      end
      PhDigit: begin
        if (hex_digit(c)) begin
          emit({nibble_of(held_digit), nibble_of(c)}, 1'b0);
          escape_phase = PhIdle;
        end else begin
          emit(upd_pkg::ChPercent, 1'b0);
          emit(held_digit, 1'b0);
          take_plain(c);
        end
      end
      default: take_plain(c);
    endcase
    if (decoded_q.size() > n0) decoded_q[$].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t exp_r;
    if (!rst_ni) begin
      escape_phase = PhIdle;
      held_digit   = '0;
      decoded_q.delete();
    end else begin
      // input first: an output at this edge can only belong to older input
      if (in_valid_i && !in_stall_i) decode_step(in_byte_i);
      if (out_valid_i && !out_stall_i) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected output transaction, expected none, got %02h end %0b last %0b",
                   $time, out_byte_i, string_end_i, run_last_i);
          mismatch_count_o++;
        end else begin
          exp_r = decoded_q.pop_front();
          if (out_byte_i !== exp_r.data) begin
            $display("%0t: out_byte expected %02h, got %02h", $time, exp_r.data, out_byte_i);
            mismatch_count_o++;
          end
          if (string_end_i !== exp_r.term) begin
            $display("%0t: string_end expected %0b, got %0b", $time, exp_r.term,
                     string_end_i);
            mismatch_count_o++;
          end
          if (run_last_i !== exp_r.last) begin
            $display("%0t: run_last expected %0b, got %0b", $time, exp_r.last, run_last_i);
            mismatch_count_o++;
          end
        end
      end
    end
    pending_o = decoded_q.size();
  end

endmodule

FILE: tb/url_percent_decoder_core_test.sv
module url_percent_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Random part size, run limit and receiver hold-off shape.
  localparam int RandomItems   = 480;
  localparam int LimitCycles   = 200000;
  localparam int HoldOffAt     = 300;  // receiver cycle where the long hold-off starts
  localparam int HoldOffCycles = 48;   // well past the four-entry job queue
  localparam int TailItems     = 60;   // last items run with no idling at all
  localparam int DrainCycles   = 8;    // watch window for strays once nothing is pending

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       string_end_o;
  logic       run_last_o;

  int         mismatches;
  int         pending;
  int         cycles      = 0;
  bit         tail_quiet  = 1'b0;
  logic [7:0] source_q[$];

  url_percent_decoder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .string_end_o(string_end_o),
    .run_last_o  (run_last_o)
  );

  // Watches both channels, predicts decoded bytes, counts mismatches.
  percent_decode_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_i      (out_byte_o),
    .string_end_i    (string_end_o),
    .run_last_i      (run_last_o),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a dropped result or a stuck handshake ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LimitCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Hex digit in either case, picked uniformly over value and case.
  function automatic logic [7:0] random_hex_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(0, 1) == 1) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  // Any byte that breaks an escape: may be '%', '+', NUL or anything else.
  function automatic logic [7:0] random_non_hex();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    // flipping bit 6 moves every hex digit out of the hex ranges
    if (upd_pkg::is_hex(b)) b = b ^ 8'h40;
    return b;
  endfunction

  // One input transaction. Called at a falling edge and returns at one.
  // A gap drops valid ahead of the byte; once valid is up the byte is held
  // until the rising edge that sees no stall.
  task automatic send_byte(input logic [7:0] b, input bit allow_gap);
    if (allow_gap && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Receiver: short random stall bursts with calm stretches in between, one
  // long hold-off so the job queue fills and in_stall_o rises, and no stalls
  // at all once the tail of the stimulus is reached.
  initial begin
    int rx_cycles;
    rx_cycles = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycles++;
      if (rx_cycles == HoldOffAt) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
        rx_cycles += HoldOffCycles;
      end else if (!tail_quiet && ((rx_cycles / 50) % 3 != 1) &&
                   $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int kind;
    int total;

    // Directed part: extreme byte, plus, escapes in both cases, each broken
    // escape form, a percent reopening an escape, terminator mid-escape in
    // both phases, and a plus that breaks an escape after one digit.
    source_q = '{8'hFF, upd_pkg::ChPlus,
                 upd_pkg::ChPercent, "4", "1",
                 upd_pkg::ChPercent, "f", "F",
                 upd_pkg::ChPercent, "g",
                 upd_pkg::ChPercent, "3", "z",
                 upd_pkg::ChPercent, upd_pkg::ChPercent, "2", "0",
                 upd_pkg::ChPercent, "0", upd_pkg::ChNul,
                 upd_pkg::ChPercent, upd_pkg::ChNul,
                 upd_pkg::ChPercent, "a", upd_pkg::ChPlus};

    // Random part: well-formed escapes with random digits, mixed with plain
    // noise bytes (any value), plus signs, broken escapes and terminators.
    total = source_q.size() + RandomItems;
    while (source_q.size() < total) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        source_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 42) begin
        source_q.push_back(upd_pkg::ChPlus);
      end else if (kind < 72) begin
        source_q.push_back(upd_pkg::ChPercent);
        source_q.push_back(random_hex_digit());
        source_q.push_back(random_hex_digit());
      end else if (kind < 80) begin
        source_q.push_back(upd_pkg::ChPercent);
        source_q.push_back(random_non_hex());
      end else if (kind < 88) begin
        source_q.push_back(upd_pkg::ChPercent);
        source_q.push_back(random_hex_digit());
        source_q.push_back(random_non_hex());
      end else if (kind < 94) begin
        source_q.push_back(upd_pkg::ChNul);
      end else begin
        source_q.push_back(upd_pkg::ChPercent);
        if ($urandom_range(0, 1) == 1) source_q.push_back(random_hex_digit());
        source_q.push_back(upd_pkg::ChNul);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sender gaps come in bands of 40 items with every third band gap-free.
    for (int i = 0; i < source_q.size(); i++) begin
      if (i >= source_q.size() - TailItems) tail_quiet = 1'b1;
      send_byte(source_q[i], !tail_quiet && ((i / 40) % 3 != 2));
    end
    in_valid_i <= 1'b0;

    // Drain: every predicted byte must show up, then watch for strays.
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
